### hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("assertion failed");

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
   else $error("assertion failed");

`endif

### hw/rtl/bvsa_pkg.sv
package bvsa_pkg;

   localparam int CNT_W      = 16;          // index width, lists wrap at 2^16
   localparam int DIV_STEPS  = 64;          // quotient bits
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef struct packed {
      logic capture;   // take the input word
      logic prep;      // magnitudes, signs, candidate test
      logic mul1;      // |A|*|B|, d*d, (1-f)*f
      logic div_init;
      logic div_step;
      logic mul2;      // Q*G partial products
      logic add1;
      logic mul3;      // R*|obj| partial products
      logic add2;
      logic sat;
      logic update;    // running argmax
      logic advance;   // next index, list continues
      logic emit;      // load result, restart list
   } cmd_type;

   typedef struct packed {
      logic cand;
      logic last;
      logic out_free;
   } sts_type;

endpackage

### hw/rtl/branch_variable_score_argmax_unit.sv
// Branch variable scoring with running argmax.
// req channel: one variable per word (solution, bounds, objective weight,
//   last flag). A word is taken when req_valid is high and req_stall low.
// rsp channel: one word per list, after the word marked last: winning index,
//   found flag and winning score (signed, 16 fraction bits). Zeros if no
//   variable of the list was fractional.
// Processing: a non-candidate word goes through capture, prep and the
//   candidate test only; a candidate also runs the 64-step restoring divider
//   for (|A|*|B|) / (ub-lb)^2, two rounds of split 32x32 multiplies and the
//   saturation stage. One word is in flight at a time; req_stall is high while it is worked on.
// The result sits in an output register; if the receiver holds rsp_stall,
//   the word stays put and a new list may start, but the next last word
//   waits until the previous result is taken.
// Reset (synchronous) clears the running best, the index counter and the
//   output valid; the next word starts a new list at index 0.
module branch_variable_score_argmax_unit import bvsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_solution_value,
   input  logic [15:0]        req_lower_bound,
   input  logic [15:0]        req_upper_bound,
   input  logic signed [31:0] req_objective_weight,
   input  logic               req_last_variable,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_best_position,
   output logic               rsp_found,
   output logic signed [63:0] rsp_best_score
);

   cmd_type cmd;
   sts_type sts;

   bvsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bvsa_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_solution_value   (req_solution_value),
      .req_lower_bound      (req_lower_bound),
      .req_upper_bound      (req_upper_bound),
      .req_objective_weight (req_objective_weight),
      .req_last_variable    (req_last_variable),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_best_position    (rsp_best_position),
      .rsp_found            (rsp_found),
      .rsp_best_score       (rsp_best_score)
   );

endmodule

### hw/rtl/bvsa_ctrl.sv
module bvsa_ctrl import bvsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_MUL1, ST_DINIT, ST_DIV, ST_MUL2, ST_ADD1,
      ST_MUL3, ST_ADD2, ST_SAT, ST_UPD, ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            // candidate flag is valid from here on
            if (sts.cand) begin
               cmd.mul1 = 1'b1;
               state_in = ST_DINIT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_ADD1;
         end
         ST_ADD1: begin
            cmd.add1 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_ADD2;
         end
         ST_ADD2: begin
            cmd.add2 = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts.last) begin
               cmd.advance = 1'b1;
               state_in    = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### hw/rtl/bvsa_datapath.sv
module bvsa_datapath import bvsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [31:0]        req_solution_value,
   input  logic [15:0]        req_lower_bound,
   input  logic [15:0]        req_upper_bound,
   input  logic signed [31:0] req_objective_weight,
   input  logic               req_last_variable,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_best_position,
   output logic               rsp_found,
   output logic signed [63:0] rsp_best_score
);

   logic [31:0]        x_ff;
   logic [15:0]        lb_ff, ub_ff;
   logic signed [31:0] obj_ff;
   logic               last_ff;

   logic [31:0] ma_ff, mb_ff, mo_ff;
   logic [15:0] d_ff, f_ff;
   logic        neg_ff, cand_ff;

   logic [63:0] prod_ff;
   logic [31:0] d2_ff, g_ff;
   logic [63:0] quo_ff;
   logic [32:0] rem_ff;
   logic [63:0] t1_ff, t0_ff, r_ff, p1_ff, p0_ff;
   logic [95:0] acc_ff;
   logic signed [63:0] score_ff;

   logic signed [63:0] best_score_ff;
   logic [CNT_W-1:0]   best_pos_ff, count_ff;
   logic               any_ff;

   logic               rsp_valid_ff, rsp_found_ff;
   logic [15:0]        rsp_pos_ff;
   logic signed [63:0] rsp_score_ff;

   // prep logic
   logic [32:0] a_w, b_w;
   logic [31:0] ma_w, mb_w, mo_w;
   logic [15:0] d_w;
   logic        neg_w;
   logic [31:0] g_w;
   // divider step
   logic [32:0] rem_sh_w;
   logic        q_bit_w;
   // saturation
   logic        over_w, sat_w;
   logic [63:0] m_w;
   logic signed [63:0] score_w;

   always_comb begin
      a_w   = {1'b0, ub_ff, 16'h0000} - {1'b0, x_ff};
      b_w   = {1'b0, x_ff} - {1'b0, lb_ff, 16'h0000};
      ma_w  = a_w[32] ? 32'(-a_w) : a_w[31:0];
      mb_w  = b_w[32] ? 32'(-b_w) : b_w[31:0];
      mo_w  = obj_ff[31] ? (~obj_ff + 32'sd1) : obj_ff;
      d_w   = (ub_ff >= lb_ff) ? (ub_ff - lb_ff) : (lb_ff - ub_ff);
      neg_w = a_w[32] ^ b_w[32] ^ obj_ff[31];
      g_w   = {15'h0, 17'h10000 - {1'b0, f_ff}} * {16'h0, f_ff};
   end

   always_comb begin
      rem_sh_w = {rem_ff[31:0], quo_ff[63]};
      q_bit_w  = (rem_sh_w >= {1'b0, d2_ff});
   end

   always_comb begin
      m_w    = acc_ff[79:16];
      over_w = |acc_ff[95:80];
      if (neg_ff) sat_w = over_w || (m_w[63] && (|m_w[62:0]));
      else        sat_w = over_w || m_w[63];
      if (neg_ff) score_w = sat_w ? {1'b1, 63'h0} : -$signed(m_w);
      else        score_w = sat_w ? {1'b0, {63{1'b1}}} : $signed(m_w);
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff    <= req_solution_value;
         lb_ff   <= req_lower_bound;
         ub_ff   <= req_upper_bound;
         obj_ff  <= req_objective_weight;
         last_ff <= req_last_variable;
      end
      if (cmd.prep) begin
         ma_ff   <= ma_w;
         mb_ff   <= mb_w;
         mo_ff   <= mo_w;
         d_ff    <= d_w;
         f_ff    <= x_ff[15:0];
         neg_ff  <= neg_w;
         cand_ff <= (x_ff[15:0] != 16'h0) && (lb_ff != ub_ff);
      end
      if (cmd.mul1) begin
         prod_ff <= {32'h0, ma_ff} * {32'h0, mb_ff};
         d2_ff   <= {16'h0, d_ff} * {16'h0, d_ff};
         g_ff    <= g_w;
      end
      if (cmd.div_init) begin
         quo_ff <= prod_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit_w ? (rem_sh_w - {1'b0, d2_ff}) : rem_sh_w;
         quo_ff <= {quo_ff[62:0], q_bit_w};
      end
      if (cmd.mul2) begin
         t1_ff <= {32'h0, quo_ff[63:32]} * {32'h0, g_ff};
         t0_ff <= {32'h0, quo_ff[31:0]} * {32'h0, g_ff};
      end
      if (cmd.add1) r_ff <= t1_ff + {32'h0, t0_ff[63:32]};
      if (cmd.mul3) begin
         p1_ff <= {32'h0, r_ff[63:32]} * {32'h0, mo_ff};
         p0_ff <= {32'h0, r_ff[31:0]} * {32'h0, mo_ff};
      end
      if (cmd.add2) acc_ff <= {p1_ff, 32'h0} + {32'h0, p0_ff};
      if (cmd.sat)  score_ff <= score_w;
      if (cmd.emit) begin
         rsp_found_ff <= any_ff;
         rsp_pos_ff   <= any_ff ? best_pos_ff : '0;
         rsp_score_ff <= any_ff ? best_score_ff : 64'sd0;
      end
   end

   // running argmax and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= {1'b1, 63'h0};
         best_pos_ff   <= '0;
         count_ff      <= '0;
         any_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.update && (!any_ff || (score_ff > best_score_ff))) begin
            best_score_ff <= score_ff;
            best_pos_ff   <= count_ff;
            any_ff        <= 1'b1;
         end
         if (cmd.advance) count_ff <= count_ff + CNT_W'(1);
         if (cmd.emit) begin
            best_score_ff <= {1'b1, 63'h0};
            best_pos_ff   <= '0;
            count_ff      <= '0;
            any_ff        <= 1'b0;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   assign sts.cand     = cand_ff;
   assign sts.last     = last_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_best_position = rsp_pos_ff;
   assign rsp_best_score    = rsp_score_ff;

endmodule

### hw/rtl/bvsa_checker.sv
`include "assert_macros.svh"

module bvsa_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [31:0]        req_solution_value,
   input logic [15:0]        req_lower_bound,
   input logic [15:0]        req_upper_bound,
   input logic signed [31:0] req_objective_weight,
   input logic               req_last_variable,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [15:0]        rsp_best_position,
   input logic               rsp_found,
   input logic signed [63:0] rsp_best_score
);

   logic rsp_zero;

   assign rsp_zero = (rsp_best_score == 64'sd0) && (rsp_best_position == 16'h0);

   // a stalled result word stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // one word in flight: busy right after taking one
   `ASSERT_CLK(a_busy_after_take, clock, reset, req_valid && !req_stall |=> req_stall)

   // an empty list reports zeros
   `ASSERT_CLK(a_empty_zero, clock, reset, rsp_valid && !rsp_found |-> rsp_zero)

   // nothing offered right after reset
   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)

endmodule

bind branch_variable_score_argmax_unit bvsa_checker u_bvsa_checker (.*);
